// File: rtl/scfd_pkg.sv
// Package for the serial CAN frame deframer.
// Holds the framing constants and the frame record shared by all blocks.
// No dependencies.
`timescale 1ns / 1ps

package scfd_pkg;

   localparam logic [7:0] HDR_BYTE = 8'hAA;
   localparam logic [7:0] EXT_BIT  = 8'h20;
   localparam logic [7:0] TRL_BYTE = 8'h7A;
   localparam int         STD_LEN  = 17;
   localparam int         EXT_LEN  = 18;
   localparam int         FILL_W   = 5;

   typedef struct packed {
      logic [31:0] can_id;
      logic        extended;
      logic [7:0]  length_code;
      logic [63:0] payload;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/scfd_front.sv
// Front end: receive window, header search, trailer check and frame extraction.
// Pushes each good frame into the frame queue. Depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_front import scfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   input  queue_status_type queue_status,
   output logic             push,
   output frame_type        push_frame
);

   logic [7:0]          w_ff [EXT_LEN];
   logic [7:0]          w_in [EXT_LEN];
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;

   logic [7:0]          nw [EXT_LEN];
   logic [7:0]          v [STD_LEN];
   logic [STD_LEN*8-1:0] v_flat;
   logic [STD_LEN*8-1:0] shifted;
   logic                accept;
   logic                at_ext;
   logic                scan;
   logic                ext_good;
   logic                found;
   logic [FILL_W-1:0]   pos;
   logic [FILL_W-1:0]   s;
   logic                v_ext;
   logic                std_good;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < EXT_LEN; i++) begin
         nw[i] = (FILL_W'(i) == fill_ff) ? req_rx_byte : w_ff[i];
      end
      at_ext   = (fill_ff == FILL_W'(STD_LEN));
      scan     = (fill_ff >= FILL_W'(STD_LEN - 1));
      ext_good = at_ext && (nw[EXT_LEN-1] == TRL_BYTE);

      // 17-byte scan view; after a bad extended trailer the header is skipped
      for (int i = 0; i < STD_LEN; i++) begin
         v[i] = at_ext ? nw[i+1] : nw[i];
         v_flat[i*8 +: 8] = v[i];
      end

      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < STD_LEN; i++) begin
         if (!found && (v[i] == HDR_BYTE)) begin
            found = 1'b1;
            pos   = FILL_W'(i);
         end
      end

      v_ext    = ((v[1] & EXT_BIT) != 8'h00);
      std_good = (v[STD_LEN-1] == TRL_BYTE);

      if (pos == '0 && v_ext) begin
         s = '0;
      end else if (pos == '0) begin
         s = FILL_W'(1);
      end else begin
         s = pos;
      end
      shifted = v_flat >> {s, 3'b000};

      w_in       = w_ff;
      fill_in    = fill_ff;
      push       = 1'b0;
      push_frame = '0;

      if (accept) begin
         if (!scan) begin
            w_in    = nw;
            fill_in = fill_ff + FILL_W'(1);
         end else if (ext_good) begin
            push                   = 1'b1;
            push_frame.can_id      = {nw[5], nw[6], nw[7], nw[8]};
            push_frame.extended    = 1'b1;
            push_frame.length_code = nw[2];
            push_frame.payload     = {nw[16], nw[15], nw[14], nw[13],
                                      nw[12], nw[11], nw[10], nw[9]};
            fill_in                = '0;
         end else if (!found) begin
            fill_in = '0;
         end else if (pos == '0 && !v_ext && std_good) begin
            push                   = 1'b1;
            push_frame.can_id      = {16'h0000, v[6], v[7]};
            push_frame.extended    = 1'b0;
            push_frame.length_code = v[3];
            push_frame.payload     = {v[15], v[14], v[13], v[12],
                                      v[11], v[10], v[9], v[8]};
            fill_in                = '0;
         end else begin
            for (int j = 0; j < STD_LEN; j++) begin
               w_in[j] = shifted[j*8 +: 8];
            end
            fill_in = FILL_W'(STD_LEN) - s;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(STD_LEN))
      else $error("window fill above 17");

   a_wait_hdr: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == FILL_W'(STD_LEN)) |->
         (w_ff[0] == HDR_BYTE) && ((w_ff[1] & EXT_BIT) != 8'h00))
      else $error("full window not holding an extended header");

   a_push_clears: assert property (@(posedge clock) disable iff (reset)
      push |=> (fill_ff == '0))
      else $error("window not emptied after frame");

endmodule

// File: rtl/scfd_queue.sv
// Small frame queue between front end and output stage.
// Register-based FIFO of frame records. Depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_queue import scfd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_type        push_frame,
   input  logic             pop,
   output frame_type        pop_frame,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type          mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_frame    = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH)) |-> !push)
      else $error("push into full frame queue");

endmodule

// File: rtl/scfd_back.sv
// Output stage: numbers frames and holds the result register.
// Pops the frame queue. Depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_back import scfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  frame_type        pop_frame,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_can_id,
   output logic             rsp_extended,
   output logic [7:0]       rsp_length_code,
   output logic [63:0]      rsp_payload,
   output logic [63:0]      rsp_sequence_number
);

   logic        valid_ff, valid_in;
   frame_type   frame_ff;
   logic [63:0] seq_ff, seq_in;

   always_comb begin
      pop      = !queue_status.empty && (!valid_ff || rsp_ready);
      valid_in = valid_ff;
      seq_in   = seq_ff;
      if (pop) begin
         valid_in = 1'b1;
         seq_in   = seq_ff + 64'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_ff <= pop_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seq_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         seq_ff   <= seq_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_can_id          = frame_ff.can_id;
   assign rsp_extended        = frame_ff.extended;
   assign rsp_length_code     = frame_ff.length_code;
   assign rsp_payload         = frame_ff.payload;
   assign rsp_sequence_number = seq_ff;

   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_sequence_number == $past(seq_ff) + 64'd1) && rsp_valid)
      else $error("sequence number not advanced on load");

endmodule

// File: rtl/serial_can_frame_deframer.sv
// Serial CAN frame deframer, top level.
// Instantiates scfd_front, scfd_queue and scfd_back; depends on scfd_pkg.
//
//   channel  | direction | transfer when         | payload
//   req_     | in        | req_valid & req_ready | rx_byte
//   rsp_     | out       | rsp_valid & rsp_ready | can_id, extended, length_code,
//            |           |                       | payload, sequence_number
//
// One byte is taken per cycle while req_ready is high; search, check and
// extraction finish in the cycle the byte is taken. A frame goes through the
// frame queue and output register to rsp_valid. Synchronous reset empties the
// window, queue and output and zeroes the count. req_ready drops only while
// the queue is full; the output register lets bytes flow while a result waits.
`timescale 1ns / 1ps

module serial_can_frame_deframer import scfd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_can_id,
   output logic        rsp_extended,
   output logic [7:0]  rsp_length_code,
   output logic [63:0] rsp_payload,
   output logic [63:0] rsp_sequence_number
);

   queue_status_type queue_status;
   logic             push;
   logic             pop;
   frame_type        push_frame;
   frame_type        pop_frame;

   scfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .queue_status (queue_status),
      .push         (push),
      .push_frame   (push_frame)
   );

   scfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .status     (queue_status)
   );

   scfd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_status        (queue_status),
      .pop_frame           (pop_frame),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_can_id          (rsp_can_id),
      .rsp_extended        (rsp_extended),
      .rsp_length_code     (rsp_length_code),
      .rsp_payload         (rsp_payload),
      .rsp_sequence_number (rsp_sequence_number)
   );

endmodule

// File: tb/scfd_checker.sv
// Frame checker for the serial CAN frame deframer testbench.
// Watches both channels, predicts frames from the accepted byte stream and
// compares each transfer on rsp_; depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_checker import scfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_can_id,
   input  logic        rsp_extended,
   input  logic [7:0]  rsp_length_code,
   input  logic [63:0] rsp_payload,
   input  logic [63:0] rsp_sequence_number,
   output int          fail_count,
   output int          frames_pending,
   output int          bytes_taken,
   output int          frames_checked,
   output int          ext_checked
);

   typedef struct packed {
      frame_type   fr;
      logic [63:0] seq;
   } frame_expect_type;

   logic [7:0]       win [EXT_LEN];
   int               win_fill;
   logic [63:0]      frames_found;
   frame_expect_type frame_queue [$];

   function automatic void shift_out(input int n);
      if (n >= win_fill) begin
         win_fill = 0;
      end else begin
         for (int i = 0; i < win_fill - n; i++) win[i] = win[i + n];
         win_fill -= n;
      end
   endfunction

   function automatic logic [63:0] data_bytes(input int first);
      logic [63:0] v;
      for (int k = 0; k < 8; k++) v[8*k +: 8] = win[first + k];
      return v;
   endfunction

   // Append one byte to the window; returns 1 when a complete frame is found.
   function automatic bit deframe_byte(input logic [7:0] b, output frame_expect_type e);
      int pos;
      e = '0;
      if (win_fill >= EXT_LEN) shift_out(1);
      win[win_fill] = b;
      win_fill++;
      while (win_fill >= STD_LEN) begin
         pos = 0;
         while (pos < win_fill && win[pos] != HDR_BYTE) pos++;
         if (pos >= win_fill) begin
            win_fill = 0;
            return 0;
         end
         shift_out(pos);
         if (win_fill < STD_LEN) return 0;
         if ((win[1] & EXT_BIT) != 0) begin
            if (win_fill < EXT_LEN) return 0;
            if (win[17] != TRL_BYTE) begin
               shift_out(1);
               continue;
            end
            frames_found++;
            e.fr.can_id      = {win[5], win[6], win[7], win[8]};
            e.fr.extended    = 1'b1;
            e.fr.length_code = win[2];
            e.fr.payload     = data_bytes(9);
            e.seq            = frames_found;
            shift_out(EXT_LEN);
            return 1;
         end else begin
            if (win[16] != TRL_BYTE) begin
               shift_out(1);
               continue;
            end
            frames_found++;
            e.fr.can_id      = {16'h0000, win[6], win[7]};
            e.fr.extended    = 1'b0;
            e.fr.length_code = win[3];
            e.fr.payload     = data_bytes(8);
            e.seq            = frames_found;
            shift_out(STD_LEN);
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      frame_expect_type e;
      if (reset) begin
         win_fill       = 0;
         frames_found   = '0;
         fail_count     = 0;
         bytes_taken    = 0;
         frames_checked = 0;
         ext_checked    = 0;
         frame_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            bytes_taken++;
            if (deframe_byte(req_rx_byte, e)) frame_queue = {frame_queue, e};
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_queue.size() == 0) begin
               $display("%0t: unexpected frame transfer, expected none, actual id %h seq %0d",
                        $time, rsp_can_id, rsp_sequence_number);
               fail_count++;
            end else begin
               e = frame_queue[0];
               frame_queue.delete(0);
               check_field("can_id", 64'(e.fr.can_id), 64'(rsp_can_id));
               check_field("extended", 64'(e.fr.extended), 64'(rsp_extended));
               check_field("length_code", 64'(e.fr.length_code), 64'(rsp_length_code));
               check_field("payload", e.fr.payload, rsp_payload);
               check_field("sequence_number", e.seq, rsp_sequence_number);
               frames_checked++;
               if (e.fr.extended) ext_checked++;
            end
         end
      end
      frames_pending = frame_queue.size();
   end

endmodule

// File: tb/tb_serial_can_frame_deframer.sv
// Top of the serial CAN frame deframer testbench: clock, reset, byte stimulus
// and receiver stalls. Depends on scfd_pkg, serial_can_frame_deframer and scfd_checker.
`timescale 1ns / 1ps

module tb_serial_can_frame_deframer import scfd_pkg::*; ();

   localparam int NUM_BYTES   = 1700;
   localparam int HOLD_AT     = 1500;
   localparam int HOLD_CYCLES = 250;
   localparam int DRAIN       = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_can_id;
   logic        rsp_extended;
   logic [7:0]  rsp_length_code;
   logic [63:0] rsp_payload;
   logic [63:0] rsp_sequence_number;

   int fail_count, frames_pending, bytes_taken, frames_checked, ext_checked;
   int bytes_sent = 0;
   int burst_left = 0;

   always #1 clock = ~clock;

   serial_can_frame_deframer dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_rx_byte,
      .rsp_valid, .rsp_ready, .rsp_can_id, .rsp_extended, .rsp_length_code,
      .rsp_payload, .rsp_sequence_number
   );

   scfd_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_rx_byte,
      .rsp_valid, .rsp_ready, .rsp_can_id, .rsp_extended, .rsp_length_code,
      .rsp_payload, .rsp_sequence_number,
      .fail_count, .frames_pending, .bytes_taken, .frames_checked, .ext_checked
   );

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic put_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0 && !(bytes_sent > 600 && bytes_sent < 900)) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_byte(input int fill);
      if (fill == 1) return 8'hFF;
      if (fill == 2) return 8'h00;
      return 8'($urandom);
   endfunction

   // fill: 0 random content, 1 all ones, 2 all zeros; keep truncates the frame
   task automatic send_frame(input bit ext, input int fill, input logic [7:0] trl,
                             input int keep);
      logic [7:0] fb [$];
      logic [7:0] typ, dlc;
      typ = pick_byte(fill);
      typ = ext ? (typ | EXT_BIT) : (typ & ~EXT_BIT);
      dlc = (fill == 0 && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 8))
                                                     : pick_byte(fill);
      fb = {fb, HDR_BYTE};
      fb = {fb, typ};
      if (ext) begin
         fb = {fb, dlc};
         repeat (6) fb = {fb, pick_byte(fill)};
      end else begin
         fb = {fb, pick_byte(fill)};
         fb = {fb, dlc};
         repeat (4) fb = {fb, pick_byte(fill)};
      end
      repeat (8) fb = {fb, pick_byte(fill)};
      fb = {fb, trl};
      for (int i = 0; i < keep && i < fb.size(); i++) put_byte(fb[i]);
   endtask

   initial begin : stimulus
      int kind, fill;
      logic [7:0] trl;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // noise held while the window is short, then a frame of all-ones fields
      put_byte(8'h00);
      put_byte(8'hFF);
      send_frame(1'b0, 1, TRL_BYTE, STD_LEN);

      while (bytes_sent < NUM_BYTES) begin
         kind = $urandom_range(0, 99);
         fill = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
         if (kind < 55) begin
            send_frame(1'($urandom_range(0, 1)), fill, TRL_BYTE, EXT_LEN);
         end else if (kind < 70) begin
            do trl = 8'($urandom); while (trl == TRL_BYTE);
            send_frame(1'($urandom_range(0, 1)), fill, trl, EXT_LEN);
         end else if (kind < 80) begin
            send_frame(1'($urandom_range(0, 1)), fill, TRL_BYTE, $urandom_range(2, 16));
         end else if (kind < 92) begin
            repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 2))
                  0: put_byte(HDR_BYTE);
                  1: put_byte(TRL_BYTE);
                  default: put_byte(EXT_BIT);
               endcase
            end
         end
      end

      req_valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      $display("Sent %0d bytes: directed framing, random frames, bad trailers, cut frames",
               bytes_taken);
      $display("and noise; checked %0d frames, %0d of them extended.",
               frames_checked, ext_checked);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : receiver
      int cyc, mode;
      cyc  = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if (cyc == HOLD_AT) begin
            // long hold-off so the frame queue fills and req_ready drops
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= cyc[2];
            endcase
         end
      end
   end

   initial begin : watchdog
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
